>>> rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Short forms for clocked concurrent assertions in the tone map core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define HDTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define HDTM_ASSERT_ALWAYS(lbl, expr, msg) \
    `HDTM_ASSERT(lbl, 1'b1 |-> (expr), msg)

`endif

>>> rtl/core/hdtm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hdtm_pkg
// Types, register indexes and the tone curve threshold table of the core.
// ============================================================================
package hdtm_pkg;

    localparam int unsigned MAX_SOURCE_DIM_DEF = 8192;
    localparam int unsigned MAX_TARGET_DIM_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int SRC_REG_W  = 14;
    localparam int TGT_REG_W  = 11;
    localparam int PIX_W      = 24;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    typedef struct packed {
        logic signed [PIX_W-1:0] red_in;
        logic signed [PIX_W-1:0] green_in;
        logic signed [PIX_W-1:0] blue_in;
        logic signed [PIX_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red_out;
        logic [BYTE_W-1:0] green_out;
        logic [BYTE_W-1:0] blue_out;
        logic [BYTE_W-1:0] alpha_out;
        logic [POS_W-1:0]  out_col;
        logic [POS_W-1:0]  out_row;
        logic              frame_last;
    } pixel_out_t;

    // What a tone lane hands to the merging stage.
    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] code;
    } lane_res_t;

    typedef logic [PIX_W-1:0] thr_tab_t [256];

    // Smallest raw value X that reaches byte k, found exactly:
    // X^5 * 510^11 >= (2k-1)^11 * (65536+X)^5. Unreachable bytes get 2^23.
    function automatic logic [PIX_W-1:0] tone_thr(int k);
        logic [255:0] a510;
        logic [255:0] bk;
        logic [255:0] lhs;
        logic [255:0] rhs;
        logic [24:0]  lo;
        logic [24:0]  hi;
        logic [24:0]  mid;
        a510 = 256'd1;
        bk   = 256'd1;
        for (int i = 0; i < 11; i++)
        begin
            a510 = a510 * 256'd510;
            bk   = bk * 256'(2 * k - 1);
        end
        lo = 25'd1;
        hi = 25'h800000;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            lhs = a510;
            rhs = bk;
            for (int i = 0; i < 5; i++)
            begin
                lhs = lhs * 256'(mid);
                rhs = rhs * (256'd65536 + 256'(mid));
            end
            if (lhs >= rhs)
                hi = mid;
            else
                lo = mid + 25'd1;
        end
        return hi[PIX_W-1:0];
    endfunction

    function automatic thr_tab_t build_thr();
        thr_tab_t t;
        t[0] = '0;
        for (int k = 1; k < 256; k++)
        begin
            t[k] = tone_thr(k);
        end
        return t;
    endfunction

    localparam thr_tab_t TONE_THR = build_thr();

endpackage

>>> rtl/core/hdtm_div.sv
`timescale 1ns / 1ps
// ============================================================================
// hdtm_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module hdtm_div #(
    parameter int W = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CNT_W = $clog2(W + 1);

    logic             run_reg, run_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       trial;
    logic             qbit;

    always_comb
    begin
        trial     = {rem_reg, num_reg[W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(W);
            num_next = dividend;
            den_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next  = qbit ? W'(trial - {1'b0, den_reg}) : W'(trial);
            num_next  = num_reg << 1;
            quot_next = {quot_reg[W-2:0], qbit};
            cnt_next  = cnt_reg - CNT_W'(1);
            run_next  = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy      = run_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/core/hdtm_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// hdtm_lane
// One color lane: tone curve byte by binary search over the threshold table.
// ============================================================================
module hdtm_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [hdtm_pkg::PIX_W-1:0] value,
    output hdtm_pkg::lane_res_t               res
);
    import hdtm_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic [PIX_W-2:0]  x_reg, x_next;
    logic [BYTE_W-1:0] cand;

    always_comb
    begin
        cand      = code_reg | (BYTE_W'(1) << bit_reg);
        run_next  = run_reg;
        done_next = done_reg;
        bit_next  = bit_reg;
        code_next = code_reg;
        x_next    = x_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            bit_next  = 3'd7;
            code_next = '0;
            // Negative values clamp to zero, which maps to byte zero.
            x_next    = value[PIX_W-1] ? '0 : value[PIX_W-2:0];
        end
        else if (run_reg)
        begin
            if ({1'b0, x_reg} >= TONE_THR[cand])
                code_next = cand;
            bit_next = bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        x_reg    <= x_next;
    end

    assign res.done = done_reg;
    assign res.code = code_reg;

endmodule

>>> rtl/core/hdr_tonemap_downscale.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ============================================================================
// hdr_tonemap_downscale
// HDR preview tone mapper with nearest neighbor downscale.
// ============================================================================
// Usage:
// Source pixels enter on in_data (signed Q7.16 RGBA) in raster order, one per
// input transaction. A pixel that the nearest neighbor grid picks produces one
// output transaction carrying the tone mapped bytes, its target column and row,
// and frame_last on the final target pixel; all other pixels produce nothing.
// A pixel that is not picked is only counted and dropped. For a picked pixel, the
// three color lanes each run an 8-step binary search over the tone curve
// threshold table, then the merging stage loads the output register. in_stall
// is held while a picked pixel is in the lanes, so one pixel is in flight at
// a time.
// The output register parts the two sides: the next pixel is taken while a
// finished result waits under out_stall. A stalled result holds its payload.
// After reset and after every register write, two dividers work out the step
// quotients and remainders of the grid; in_stall stays high meanwhile. Reset
// sets all sizes to 1 and returns the counters to the start of a frame; any
// register write also restarts the frame. Write registers only while the block
// idles.
// ============================================================================
module hdr_tonemap_downscale #(
    parameter int unsigned MAX_SOURCE_DIM = hdtm_pkg::MAX_SOURCE_DIM_DEF,
    parameter int unsigned MAX_TARGET_DIM = hdtm_pkg::MAX_TARGET_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  hdtm_pkg::pixel_in_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output hdtm_pkg::pixel_out_t             out_data,
    input  logic                             cfg_we,
    input  logic [hdtm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hdtm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hdtm_pkg::*;

    localparam int DW   = $clog2(MAX_SOURCE_DIM + 1);
    localparam int TW   = $clog2(MAX_TARGET_DIM + 1);
    localparam int DIVW = (DW > TW) ? DW : TW;

    // Zero counts as one, anything above the limit as the limit.
    function automatic int unsigned clamp_dim(logic [SRC_REG_W-1:0] v, int unsigned mx);
        int unsigned r;
        r = (v == '0) ? 1 : int'(v);
        return (r > mx) ? mx : r;
    endfunction

    // Configuration registers.
    logic [SRC_REG_W-1:0] src_w_reg, src_h_reg;
    logic [TGT_REG_W-1:0] tgt_w_reg, tgt_h_reg;
    logic                 pend_reg;

    int unsigned          sw_c, sh_c, tw_c, th_c;
    logic [DW-1:0]        sw_eff, sh_eff;
    logic [TW-1:0]        tw_eff, th_eff;

    always_comb
    begin
        sw_c   = clamp_dim(src_w_reg, MAX_SOURCE_DIM);
        sh_c   = clamp_dim(src_h_reg, MAX_SOURCE_DIM);
        tw_c   = clamp_dim(SRC_REG_W'(tgt_w_reg), MAX_TARGET_DIM);
        th_c   = clamp_dim(SRC_REG_W'(tgt_h_reg), MAX_TARGET_DIM);
        sw_eff = DW'(sw_c);
        sh_eff = DW'(sh_c);
        // A target larger than the source saturates to the source size.
        tw_eff = TW'((tw_c > sw_c) ? sw_c : tw_c);
        th_eff = TW'((th_c > sh_c) ? sh_c : th_c);
    end

    // Grid step dividers, restarted after reset and after every write.
    logic            cdiv_busy, rdiv_busy;
    logic [DIVW-1:0] col_q, col_r, row_q, row_r;

    hdtm_div #(.W(DIVW)) u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pend_reg),
        .dividend  (DIVW'(sw_eff)),
        .divisor   (DIVW'(tw_eff)),
        .busy      (cdiv_busy),
        .quotient  (col_q),
        .remainder (col_r)
    );

    hdtm_div #(.W(DIVW)) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pend_reg),
        .dividend  (DIVW'(sh_eff)),
        .divisor   (DIVW'(th_eff)),
        .busy      (rdiv_busy),
        .quotient  (row_q),
        .remainder (row_r)
    );

    // Frame position counters.
    logic [DW-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [TW-1:0] tgt_col_reg, tgt_col_next, tgt_row_reg, tgt_row_next;
    logic [DW-1:0] npc_reg, npc_next, npr_reg, npr_next;
    logic [TW-1:0] crem_reg, crem_next, rrem_reg, rrem_next;

    logic busy_reg, busy_next;
    logic in_fire, row_hit, emit, row_end, frame_end;
    logic col_adv, row_adv, last_pix;
    logic [TW:0] csum, rsum;

    assign in_stall = busy_reg || pend_reg || cdiv_busy || rdiv_busy;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        row_hit   = (src_row_reg == npr_reg);
        emit      = row_hit && (src_col_reg == npc_reg);
        row_end   = ({1'b0, src_col_reg} + 1'b1) >= {1'b0, sw_eff};
        frame_end = ({1'b0, src_row_reg} + 1'b1) >= {1'b0, sh_eff};
        col_adv   = emit && (({1'b0, tgt_col_reg} + 1'b1) < {1'b0, tw_eff});
        row_adv   = row_hit && (({1'b0, tgt_row_reg} + 1'b1) < {1'b0, th_eff});
        last_pix  = (({1'b0, tgt_col_reg} + 1'b1) == {1'b0, tw_eff})
                 && (({1'b0, tgt_row_reg} + 1'b1) == {1'b0, th_eff});
        csum      = {1'b0, crem_reg} + {1'b0, TW'(col_r)};
        rsum      = {1'b0, rrem_reg} + {1'b0, TW'(row_r)};

        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        tgt_col_next = tgt_col_reg;
        tgt_row_next = tgt_row_reg;
        npc_next     = npc_reg;
        npr_next     = npr_reg;
        crem_next    = crem_reg;
        rrem_next    = rrem_reg;

        if (in_fire)
        begin
            if (col_adv)
            begin
                tgt_col_next = tgt_col_reg + TW'(1);
                if (csum >= {1'b0, tw_eff})
                begin
                    crem_next = TW'(csum - {1'b0, tw_eff});
                    npc_next  = npc_reg + DW'(col_q) + DW'(1);
                end
                else
                begin
                    crem_next = TW'(csum);
                    npc_next  = npc_reg + DW'(col_q);
                end
            end
            if (row_end)
            begin
                src_col_next = '0;
                tgt_col_next = '0;
                npc_next     = '0;
                crem_next    = '0;
                if (frame_end)
                begin
                    src_row_next = '0;
                    tgt_row_next = '0;
                    npr_next     = '0;
                    rrem_next    = '0;
                end
                else
                begin
                    if (row_adv)
                    begin
                        tgt_row_next = tgt_row_reg + TW'(1);
                        if (rsum >= {1'b0, th_eff})
                        begin
                            rrem_next = TW'(rsum - {1'b0, th_eff});
                            npr_next  = npr_reg + DW'(row_q) + DW'(1);
                        end
                        else
                        begin
                            rrem_next = TW'(rsum);
                            npr_next  = npr_reg + DW'(row_q);
                        end
                    end
                    src_row_next = src_row_reg + DW'(1);
                end
            end
            else
            begin
                src_col_next = src_col_reg + DW'(1);
            end
        end
    end

    // Color lanes, one per channel.
    lane_res_t lane_r, lane_g, lane_b;
    logic      lane_start;

    assign lane_start = in_fire && emit;

    hdtm_lane u_lane_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .value (in_data.red_in),
        .res   (lane_r)
    );

    hdtm_lane u_lane_g (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .value (in_data.green_in),
        .res   (lane_g)
    );

    hdtm_lane u_lane_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .value (in_data.blue_in),
        .res   (lane_b)
    );

    // Alpha and position of the pixel in flight, captured when it enters.
    logic [BYTE_W-1:0] alpha_hold_reg, alpha_byte;
    logic [POS_W-1:0]  col_hold_reg, row_hold_reg;
    logic              last_hold_reg;
    logic [PIX_W-1:0]  alpha_prod;

    always_comb
    begin
        alpha_prod = PIX_W'(in_data.alpha_in[15:0]) * PIX_W'(255) + PIX_W'(32768);
        if (in_data.alpha_in[PIX_W-1])
            alpha_byte = '0;
        else if (in_data.alpha_in[PIX_W-2:16] != '0)
            alpha_byte = 8'd255;
        else
            alpha_byte = alpha_prod[PIX_W-1:16];
    end

    // Merging stage: all lanes finished, output register free or draining.
    logic       xfer, out_valid_reg, out_valid_next;
    pixel_out_t out_data_reg;

    assign xfer = busy_reg && lane_r.done && lane_g.done && lane_b.done
               && (!out_valid_reg || !out_stall);

    always_comb
    begin
        busy_next = busy_reg;
        if (lane_start)
            busy_next = 1'b1;
        else if (xfer)
            busy_next = 1'b0;
        if (xfer)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg     <= SRC_REG_W'(1);
            src_h_reg     <= SRC_REG_W'(1);
            tgt_w_reg     <= TGT_REG_W'(1);
            tgt_h_reg     <= TGT_REG_W'(1);
            pend_reg      <= 1'b1;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            tgt_col_reg   <= '0;
            tgt_row_reg   <= '0;
            npc_reg       <= '0;
            npr_reg       <= '0;
            crem_reg      <= '0;
            rrem_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                    REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                    REG_TARGET_WIDTH:  tgt_w_reg <= cfg_data[TGT_REG_W-1:0];
                    REG_TARGET_HEIGHT: tgt_h_reg <= cfg_data[TGT_REG_W-1:0];
                    default:           src_w_reg <= src_w_reg;
                endcase
                // Any register write restarts the frame.
                src_col_reg <= '0;
                src_row_reg <= '0;
                tgt_col_reg <= '0;
                tgt_row_reg <= '0;
                npc_reg     <= '0;
                npr_reg     <= '0;
                crem_reg    <= '0;
                rrem_reg    <= '0;
            end
            else
            begin
                src_col_reg <= src_col_next;
                src_row_reg <= src_row_next;
                tgt_col_reg <= tgt_col_next;
                tgt_row_reg <= tgt_row_next;
                npc_reg     <= npc_next;
                npr_reg     <= npr_next;
                crem_reg    <= crem_next;
                rrem_reg    <= rrem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_start)
        begin
            alpha_hold_reg <= alpha_byte;
            col_hold_reg   <= POS_W'(tgt_col_reg);
            row_hold_reg   <= POS_W'(tgt_row_reg);
            last_hold_reg  <= last_pix;
        end
        if (xfer)
        begin
            out_data_reg.red_out    <= lane_r.code;
            out_data_reg.green_out  <= lane_g.code;
            out_data_reg.blue_out   <= lane_b.code;
            out_data_reg.alpha_out  <= alpha_hold_reg;
            out_data_reg.out_col    <= col_hold_reg;
            out_data_reg.out_row    <= row_hold_reg;
            out_data_reg.frame_last <= last_hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The target and source column counters and the column remainder stay inside the grid.
    `HDTM_ASSERT_ALWAYS(a_tgt_col_bound, tgt_col_reg < tw_eff, "target column out of range")
    `HDTM_ASSERT_ALWAYS(a_col_rem_bound, crem_reg < tw_eff, "column remainder out of range")
    `HDTM_ASSERT_ALWAYS(a_src_col_bound, src_col_reg < sw_eff, "source column out of range")

endmodule

>>> sim/hdr_tonemap_downscale_test.sv
`timescale 1ns / 1ps
// ============================================================================
// hdr_tonemap_downscale_test
// Self-checking testbench for the HDR tone mapper with downscale. It drives
// pixel frames through several grid sizes, predicts every picked pixel and
// compares each output transaction field by field.
// ============================================================================
module hdr_tonemap_downscale_test;

    import hdtm_pkg::*;

    localparam int unsigned SRC_CAP    = 8192;
    localparam int unsigned TGT_CAP    = 1024;
    localparam int          QUIET_GAP  = 40;    // covers the lane search and divider setup
    localparam int          STALL_HOLD = 300;   // long receiver hold-off
    localparam int          WATCHDOG   = 3000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    pixel_in_t  in_data;
    logic       out_valid;
    logic       out_stall;
    pixel_out_t out_data;
    logic       cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Pixels waiting to be offered, and picked pixels waiting to come out.
    pixel_in_t  pixel_backlog[$];
    pixel_out_t picked_pixels[$];

    // Own copy of the size registers and the grid counters.
    int unsigned src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    int unsigned at_src_col, at_src_row, at_tgt_col, at_tgt_row;
    int unsigned pick_col, col_rem, pick_row, row_rem;

    int  errors;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  hold_request;
    bit  idling_on;
    int  quiet_cycles;

    hdr_tonemap_downscale u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Tone curve byte: largest k with X^5 * 510^11 >= (2k-1)^11 * (65536+X)^5,
    // found by binary search with exact wide integers.
    function automatic logic [7:0] tone_code(logic [23:0] raw);
        logic [255:0] lhs;
        logic [255:0] rhs;
        int lo;
        int hi;
        int mid;
        if (raw[23] || raw[22:0] == '0)
            return 8'd0;
        lhs = 256'd1;
        for (int i = 0; i < 5; i++)
            lhs = lhs * 256'(raw[22:0]);
        for (int i = 0; i < 11; i++)
            lhs = lhs * 256'd510;
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            rhs = 256'd1;
            for (int i = 0; i < 11; i++)
                rhs = rhs * 256'(2 * mid - 1);
            for (int i = 0; i < 5; i++)
                rhs = rhs * (256'd65536 + 256'(raw[22:0]));
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 8'(lo);
    endfunction

    // Alpha clamps to zero..one and rounds half up to a byte.
    function automatic logic [7:0] alpha_code(logic [23:0] raw);
        int unsigned a;
        if (raw[23])
            return 8'd0;
        a = raw[22:0];
        if (a >= 65536)
            return 8'd255;
        return 8'((255 * a + 32768) >> 16);
    endfunction

    function automatic int unsigned fit_dim(int unsigned v, int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : v;
    endfunction

    function automatic void restart_frame();
        at_src_col = 0;
        at_src_row = 0;
        at_tgt_col = 0;
        at_tgt_row = 0;
        pick_col   = 0;
        col_rem    = 0;
        pick_row   = 0;
        row_rem    = 0;
    endfunction

    // Advances the grid by one source pixel and queues the output pixel
    // when the pixel lies on a picked row and column.
    function automatic void predict_pixel(pixel_in_t px);
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        bit          row_hit;
        pixel_out_t  res;
        sw = fit_dim(src_w_reg, SRC_CAP);
        sh = fit_dim(src_h_reg, SRC_CAP);
        tw = fit_dim(tgt_w_reg, TGT_CAP);
        th = fit_dim(tgt_h_reg, TGT_CAP);
        if (tw > sw)
            tw = sw;
        if (th > sh)
            th = sh;
        row_hit = (at_src_row == pick_row);
        if (row_hit && at_src_col == pick_col)
        begin
            res.red_out    = tone_code(px.red_in);
            res.green_out  = tone_code(px.green_in);
            res.blue_out   = tone_code(px.blue_in);
            res.alpha_out  = alpha_code(px.alpha_in);
            res.out_col    = 10'(at_tgt_col);
            res.out_row    = 10'(at_tgt_row);
            res.frame_last = (at_tgt_col + 1 == tw) && (at_tgt_row + 1 == th);
            picked_pixels.push_back(res);
            if (at_tgt_col + 1 < tw)
            begin
                at_tgt_col++;
                pick_col += sw / tw;
                col_rem  += sw % tw;
                if (col_rem >= tw)
                begin
                    col_rem -= tw;
                    pick_col++;
                end
            end
        end
        if (at_src_col + 1 >= sw)
        begin
            at_src_col = 0;
            at_tgt_col = 0;
            pick_col   = 0;
            col_rem    = 0;
            if (at_src_row + 1 >= sh)
                restart_frame();
            else
            begin
                if (row_hit && at_tgt_row + 1 < th)
                begin
                    at_tgt_row++;
                    pick_row += sh / th;
                    row_rem  += sh % th;
                    if (row_rem >= th)
                    begin
                        row_rem -= th;
                        pick_row++;
                    end
                end
                at_src_row++;
            end
        end
        else
            at_src_col++;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the backlog one pixel per transaction, with random gaps.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixel(in_data);
                void'(pixel_backlog.pop_front());
                if (idling_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 5);
            end
            // A stalled payload stays put; only a free slot takes a new one.
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pixel_backlog[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap   = 0;
            hold_left  = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = STALL_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every output transaction must match the oldest picked pixel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (picked_pixels.size() == 0)
            begin
                $error("output transaction with no picked pixel pending: %p", out_data);
                errors++;
            end
            else
            begin
                want = picked_pixels.pop_front();
                if (out_data.red_out !== want.red_out)
                begin
                    $error("red_out expected %0d got %0d", want.red_out, out_data.red_out);
                    errors++;
                end
                if (out_data.green_out !== want.green_out)
                begin
                    $error("green_out expected %0d got %0d", want.green_out,
                           out_data.green_out);
                    errors++;
                end
                if (out_data.blue_out !== want.blue_out)
                begin
                    $error("blue_out expected %0d got %0d", want.blue_out, out_data.blue_out);
                    errors++;
                end
                if (out_data.alpha_out !== want.alpha_out)
                begin
                    $error("alpha_out expected %0d got %0d", want.alpha_out,
                           out_data.alpha_out);
                    errors++;
                end
                if (out_data.out_col !== want.out_col)
                begin
                    $error("out_col expected %0d got %0d", want.out_col, out_data.out_col);
                    errors++;
                end
                if (out_data.out_row !== want.out_row)
                begin
                    $error("out_row expected %0d got %0d", want.out_row, out_data.out_row);
                    errors++;
                end
                if (out_data.frame_last !== want.frame_last)
                begin
                    $error("frame_last expected %0d got %0d", want.frame_last,
                           out_data.frame_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Colour value: most often the useful range from zero to four, sometimes tiny, negative or anything.
    function automatic logic [23:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 24'($urandom());
            1:       return 24'($urandom_range(0, 24'h7FFFFF));
            2:       return 24'h800000 | 24'($urandom());
            3:       return 24'($urandom_range(0, 16));
            default: return 24'($urandom_range(0, 24'h40000));
        endcase
    endfunction

    function automatic logic [23:0] pick_alpha();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom());
            1:       return 24'($urandom_range(24'hFF00, 24'h10100));
            default: return 24'($urandom_range(0, 24'h10000));
        endcase
    endfunction

    function automatic pixel_in_t make_pixel(logic [23:0] r, logic [23:0] g,
                                             logic [23:0] b, logic [23:0] a);
        pixel_in_t px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        px.alpha_in = a;
        return px;
    endfunction

    // Waits until the block has drained and settled, so registers may change.
    task automatic wait_drained();
        while (pixel_backlog.size() > 0 || in_valid || picked_pixels.size() > 0)
            @(posedge clk);
        repeat (QUIET_GAP) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        case (idx)
            REG_SOURCE_WIDTH:  src_w_reg = value & 14'h3FFF;
            REG_SOURCE_HEIGHT: src_h_reg = value & 14'h3FFF;
            REG_TARGET_WIDTH:  tgt_w_reg = value & 11'h7FF;
            REG_TARGET_HEIGHT: tgt_h_reg = value & 11'h7FF;
            default: ;
        endcase
        restart_frame();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(int unsigned sw, int unsigned sh, int unsigned tw,
                            int unsigned th);
        wait_drained();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pixel_backlog.push_back(make_pixel(pick_level(), pick_level(), pick_level(),
                                               pick_alpha()));
    endtask

    initial
    begin
        int unsigned sw;
        int unsigned sh;
        errors       = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        idling_on    = 1'b1;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        src_w_reg    = 1;
        src_h_reg    = 1;
        tgt_w_reg    = 1;
        tgt_h_reg    = 1;
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size of 1x1: every pixel is picked and
        // ends a frame. Covers zero, tiny, negative, full scale and the
        // alpha edges around zero and one.
        pixel_backlog.push_back(make_pixel(24'h000000, 24'h000001, 24'h7FFFFF, 24'h000000));
        pixel_backlog.push_back(make_pixel(24'h800000, 24'hFFFFFF, 24'h010000, 24'h010000));
        pixel_backlog.push_back(make_pixel(24'h010000, 24'h008000, 24'h000100, 24'h00FFFF));
        pixel_backlog.push_back(make_pixel(24'h7FFFFF, 24'h800000, 24'h000002, 24'h7FFFFF));
        pixel_backlog.push_back(make_pixel(24'h555555, 24'h2AAAAA, 24'h000010, 24'h800000));
        pixel_backlog.push_back(make_pixel(24'h000080, 24'h001000, 24'h0FFFFF, 24'h008000));
        pixel_backlog.push_back(make_pixel(24'hAAAAAA, 24'h123456, 24'h654321, 24'h00807F));
        pixel_backlog.push_back(make_pixel(24'h000003, 24'h03FFFF, 24'h400000, 24'hFFFFFF));

        // Small grid with a partial step, then out-of-range sizes: zero
        // counts as one, oversize sources and targets saturate.
        set_grid(4, 3, 2, 2);
        queue_random(12);
        set_grid(0, 0, 0, 0);
        queue_random(3);
        set_grid(16383, 2, 2047, 1);
        queue_random(40);
        set_grid(3, 3, 9, 9);
        queue_random(9);

        // Random grids, one or two whole frames each.
        for (int phase = 0; phase < 11; phase++)
        begin
            sw = $urandom_range(1, 10);
            sh = $urandom_range(1, 6);
            set_grid(sw, sh, $urandom_range(0, 12), $urandom_range(0, 8));
            idling_on = (phase % 3 != 2);
            if (phase == 5)
            begin
                // Long receiver hold-off while pixels keep coming.
                idling_on    = 1'b0;
                hold_request = 1'b1;
            end
            queue_random(sw * sh * $urandom_range(1, 2) + $urandom_range(0, 3));
        end

        // Final stretch runs flat out.
        set_grid(9, 4, 4, 4);
        idling_on = 1'b0;
        queue_random(40);

        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> hdr_tonemap_downscale.f
+incdir+rtl/core
rtl/core/hdtm_pkg.sv
rtl/core/hdtm_div.sv
rtl/core/hdtm_lane.sv
rtl/core/hdr_tonemap_downscale.sv
sim/hdr_tonemap_downscale_test.sv
